FILE: rtl/fob_pkg.sv
// ----------------------------------------------------------------------------
// fob_pkg
// Item types and command codes of the factor oracle builder.
// ----------------------------------------------------------------------------
package fob_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] symbol;
  } fob_in_t;

  typedef struct packed {
    logic [8:0] position;
    logic [7:0] suffix_link;
    logic [7:0] repeat_length;
    logic       full_res;
  } fob_out_t;

endpackage

FILE: rtl/fob_ram.sv
// ----------------------------------------------------------------------------
// fob_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fob_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/factor_oracle_builder_unit.sv
// ----------------------------------------------------------------------------
// factor_oracle_builder_unit
// Online factor oracle construction with longest repeated suffix lengths.
// ----------------------------------------------------------------------------
// One result per item, on result for one cycle with valid; the receiver cannot
// stall it. An append walks suffix links, searches for the common suffix and
// scans states for a better link, paced by the single read port of the link
// and length stores. A refused append answers in the next cycle.
// After reset and after every clear the transition table is swept, one entry a
// cycle, MAX_LEN * 2**SYMBOL_BITS entries (65536 by default), with busy high;
// a clear's result comes at the end of that sweep.
module factor_oracle_builder_unit
  import fob_pkg::*;
#(
  parameter int MAX_LEN     = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  fob_in_t  cmd,
  output logic     valid,
  output fob_out_t result
);

  localparam int SW     = $clog2(MAX_LEN + 1);
  localparam int SYW    = $clog2(MAX_LEN);
  localparam int TDEPTH = MAX_LEN * (2 ** SYMBOL_BITS);
  localparam int TAW    = $clog2(TDEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_K     = 10'b0000000010,
    S_T     = 10'b0000000100,
    S_CS1   = 10'b0000001000,
    S_CS2   = 10'b0000010000,
    S_B0    = 10'b0000100000,
    S_B1    = 10'b0001000000,
    S_SCAN  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SWEEP = 10'b1000000000
  } state_t;

  state_t state;

  logic [SW-1:0]          cnt, i, k, phi, s, l, p2, s1, lp1, j, steps;
  logic [SYMBOL_BITS-1:0] a, c;
  logic [TAW-1:0]         sw;
  logic                   clr_pend;

  logic                   t_we;
  logic [TAW-1:0]         t_wa, t_ra;
  logic [SW-1:0]          t_wd, t_rd;
  logic                   l_we;
  logic [SW-1:0]          l_wa, l_ra, l_wd_link, l_wd_len, link_rd, len_rd;
  logic                   y_we;
  logic [SYW-1:0]         y_wa, y_ra;
  logic [SYMBOL_BITS-1:0] y_rd;

  logic                   accept;
  logic [SW-1:0]          s_m1, j_nx, cs_min;
  logic                   match;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign s_m1   = s - 1'b1;
  assign j_nx   = j + 1'b1;
  assign cs_min = (lp1 <= len_rd) ? lp1 : len_rd;
  assign match  = (link_rd == s) && (len_rd == l) && (j > l) && (y_rd == c);

  fob_ram #(.DEPTH(TDEPTH), .WIDTH(SW)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  fob_ram #(.DEPTH(MAX_LEN + 1), .WIDTH(SW)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd_link), .raddr(l_ra), .rdata(link_rd)
  );
  fob_ram #(.DEPTH(MAX_LEN + 1), .WIDTH(SW)) u_len (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd_len), .raddr(l_ra), .rdata(len_rd)
  );
  fob_ram #(.DEPTH(MAX_LEN), .WIDTH(SYMBOL_BITS)) u_sym (
    .clk(clk), .we(y_we), .waddr(y_wa), .wdata(cmd.symbol[SYMBOL_BITS-1:0]),
    .raddr(y_ra), .rdata(y_rd)
  );

  // memory port steering
  always_comb begin
    t_we      = 1'b0;
    t_wa      = TAW'({k, a});
    t_wd      = i;
    t_ra      = TAW'({link_rd, a});
    l_we      = 1'b0;
    l_wa      = i;
    l_wd_link = s;
    l_wd_len  = l;
    l_ra      = cnt;
    y_we      = 1'b0;
    y_wa      = SYW'(cnt);
    y_ra      = SYW'(i - l - 1'b1);
    unique case (state)
      S_IDLE: begin
        // forward transition and symbol go in straight from the item
        if (accept && cmd.op == OP_APPEND && cnt != SW'(MAX_LEN)) begin
          t_we = 1'b1;
          t_wa = TAW'({cnt, cmd.symbol[SYMBOL_BITS-1:0]});
          t_wd = cnt + 1'b1;
          y_we = 1'b1;
        end
      end
      S_T: begin
        if (t_rd == '0) begin
          t_we = 1'b1;
          l_ra = k;
        end else begin
          l_ra = phi;
        end
      end
      S_CS1:  l_ra = s_m1;
      S_CS2:  l_ra = link_rd;
      S_B0:   y_ra = SYW'(i - l - 1'b1);
      S_B1: begin
        l_ra = SW'(1);
        y_ra = SYW'(SW'(1) - l - 1'b1);
      end
      S_SCAN: begin
        l_ra = j_nx;
        y_ra = SYW'(j_nx - l - 1'b1);
      end
      S_FIN:  l_we = 1'b1;
      S_SWEEP: begin
        t_we      = 1'b1;
        t_wa      = sw;
        t_wd      = '0;
        l_we      = 1'b1;
        l_wa      = '0;
        l_wd_link = '0;
        l_wd_len  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      sw       <= '0;
      cnt      <= '0;
      clr_pend <= 1'b0;
      valid    <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.op == OP_CLEAR) begin
              state    <= S_SWEEP;
              sw       <= '0;
              cnt      <= '0;
              clr_pend <= 1'b1;
            end else if (cnt == SW'(MAX_LEN)) begin
              valid  <= 1'b1;
              result <= '{position: 9'(cnt), suffix_link: '0,
                          repeat_length: '0, full_res: 1'b1};
            end else begin
              a   <= cmd.symbol[SYMBOL_BITS-1:0];
              i   <= cnt + 1'b1;
              phi <= cnt;
              if (cnt == '0) begin
                s     <= '0;
                l     <= '0;
                state <= S_B0;
              end else begin
                state <= S_K;
              end
            end
          end
        end
        S_K: begin
          k     <= link_rd;
          state <= S_T;
        end
        S_T: begin
          if (t_rd == '0) begin
            phi <= k;
            if (k == '0) begin
              s     <= '0;
              l     <= '0;
              state <= S_B0;
            end else begin
              state <= S_K;
            end
          end else begin
            s <= t_rd;
            if (phi == '0) begin
              l     <= SW'(1);
              state <= S_B0;
            end else begin
              state <= S_CS1;
            end
          end
        end
        S_CS1: begin
          s1  <= link_rd;
          lp1 <= len_rd;
          if (s_m1 == link_rd) begin
            l     <= len_rd + 1'b1;
            state <= S_B0;
          end else begin
            p2    <= s_m1;
            steps <= '0;
            state <= S_CS2;
          end
        end
        S_CS2: begin
          if (p2 == '0 || link_rd == s1 || steps == SW'(MAX_LEN)) begin
            l     <= cs_min + 1'b1;
            state <= S_B0;
          end else begin
            p2    <= link_rd;
            steps <= steps + 1'b1;
          end
        end
        S_B0: begin
          state <= (l < i) ? S_B1 : S_FIN;
        end
        S_B1: begin
          c     <= y_rd;
          j     <= SW'(1);
          state <= (i == SW'(1)) ? S_FIN : S_SCAN;
        end
        S_SCAN: begin
          if (match) begin
            s     <= j;
            l     <= l + 1'b1;
            state <= S_FIN;
          end else if (j_nx == i) begin
            state <= S_FIN;
          end else begin
            j <= j_nx;
          end
        end
        S_FIN: begin
          cnt    <= i;
          valid  <= 1'b1;
          result <= '{position: 9'(i), suffix_link: 8'(s),
                      repeat_length: 8'(l), full_res: 1'b0};
          state  <= S_IDLE;
        end
        S_SWEEP: begin
          if (sw == TAW'(TDEPTH - 1)) begin
            state <= S_IDLE;
            if (clr_pend) begin
              valid  <= 1'b1;
              result <= '0;
            end
            clr_pend <= 1'b0;
          end else begin
            sw <= sw + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
